### rtl/frame_timer_bank_core_defines.svh
// assertion macros for the frame timer bank
`ifndef FRAME_TIMER_BANK_CORE_DEFINES_SVH
`define FRAME_TIMER_BANK_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define FTB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define FTB_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FTB_ASSERT(label, clk, rst_n, prop)
`define FTB_ASSERT_RST(label, clk, prop)
`endif
`endif

### rtl/ftb_pkg.sv
package ftb_pkg;
  localparam int unsigned TimerSlotsDef = 16;
  localparam int unsigned IdBitsDef = 16;
  localparam int unsigned TpsReset = 10000000;
  localparam int unsigned MaxDeltaReset = 333333;
  localparam logic [32:0] Sat33 = 33'h1_FFFF_FFFF;

  typedef enum logic [1:0] {
    ActStart  = 2'd0,
    ActTick   = 2'd1,
    ActAdd    = 2'd2,
    ActRemove = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KindFired = 2'd0,
    KindTick  = 2'd1,
    KindAdd   = 2'd2,
    KindAck   = 2'd3
  } kind_e;

  localparam logic RegTps = 1'b0;
  localparam logic RegMaxDelta = 1'b1;

  // one result beat from the sequencer to the output stage
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] timer_id;
    logic [31:0] frame_rate;
    logic        table_full;
    logic        last;
  } result_t;

  function automatic logic [32:0] sat_add33(logic [32:0] a, logic [32:0] b);
    logic [33:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[33] ? Sat33 : s[32:0];
  endfunction
endpackage

### rtl/ftb_slot_mem.sv
module ftb_slot_mem #(
  parameter int unsigned TimerSlots = ftb_pkg::TimerSlotsDef,
  parameter int unsigned IdBits = ftb_pkg::IdBitsDef,
  localparam int unsigned AddrW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1,
  localparam int unsigned EntW = IdBits + 32 + 33
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [EntW-1:0]  wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [EntW-1:0]  rdata_o
);
  import ftb_pkg::*;
  // id, interval, elapsed per slot
  logic [EntW-1:0] mem [TimerSlots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

### rtl/ftb_out_stage.sv
module ftb_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ftb_pkg::result_t  data_i,
  output logic              full_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output ftb_pkg::result_t  data_o
);
  import ftb_pkg::*;
  logic valid_q;
  result_t data_q;

  assign full_o = valid_q && !m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign data_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end
endmodule

### rtl/frame_timer_bank_core.sv
// frame timer bank: start latches a 64-bit counter reading; tick forms the
// clamped delta, updates the frame-rate measurement and walks every timer slot
// through the slot memory (read, then update, then emit and write back per
// slot), emitting one fired beat per expiring timer in slot order followed by
// a tick-done beat with tlast. a tick keeps the input closed from its accept
// until its walk is done (read, update and emit per slot, then a finish
// state), and each fired or tick-done beat waits further while the output
// register is held by a stalled receiver; a remove walks the slot ids (read
// and compare per slot, then a finish state) and then acks; start and add
// answer in their accept cycle, the beat showing on the next cycle, and input
// ready also waits for the output register to be free. one item is in work at
// a time. new ids wrap modulo 2^ID_BITS; adds go live at the end of the next
// tick and removes drop the slot after that tick's fire pass.
`include "frame_timer_bank_core_defines.svh"
module frame_timer_bank_core #(
  parameter int unsigned TIMER_SLOTS = ftb_pkg::TimerSlotsDef,
  parameter int unsigned ID_BITS = ftb_pkg::IdBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action[1:0], counter_value[65:2], timer_interval[97:66], repeat_req[98],
  // target_id[114:99], zeros above
  input  logic [119:0] s_axis_tdata,
  input  logic         m_axis_tready,
  output logic         m_axis_tvalid,
  // timer_id[15:0], frame_rate[47:16], table_full[48], zeros above
  output logic [55:0]  m_axis_tdata,
  // kind[1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);
  import ftb_pkg::*;
  localparam int unsigned AddrW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned EntW = ID_BITS + 32 + 33;

  typedef enum logic [2:0] {
    StIdle, StRead, StUpd, StEmit, StFinish
  } state_e;

  state_e state_q;
  logic [31:0] tps_q, maxd_q;
  logic [63:0] prev_q;
  logic [31:0] frames_q, rate_q;
  logic [32:0] fsum_q;
  logic [ID_BITS-1:0] next_id_q;
  logic [TIMER_SLOTS-1:0] act_q, pend_q, rem_q, loop_q;
  logic [CntW-1:0] idx_q;
  logic [31:0] delta_q;
  logic [32:0] el_q;
  result_t res;
  logic push, ofull;
  result_t odata;

  // input field unpack
  logic [1:0]  in_act;
  logic [63:0] in_cv;
  logic [31:0] in_ivl;
  logic        in_rep;
  logic [15:0] in_tid;
  assign in_act = s_axis_tdata[1:0];
  assign in_cv  = s_axis_tdata[65:2];
  assign in_ivl = s_axis_tdata[97:66];
  assign in_rep = s_axis_tdata[98];
  assign in_tid = s_axis_tdata[114:99];

  assign s_axis_tready = (state_q == StIdle) && !ofull;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // slot memory
  logic mwe, mre;
  logic [AddrW-1:0] mwa, mra;
  logic [EntW-1:0] mwd, mrd;
  ftb_slot_mem #(.TimerSlots(TIMER_SLOTS), .IdBits(ID_BITS)) u_mem (
    .clk_i, .we_i(mwe), .waddr_i(mwa), .wdata_i(mwd),
    .re_i(mre), .raddr_i(mra), .rdata_o(mrd)
  );
  logic [ID_BITS-1:0] rd_id;
  logic [31:0] rd_ivl;
  logic [32:0] rd_el;
  assign rd_id  = mrd[EntW-1 -: ID_BITS];
  assign rd_ivl = mrd[64:33];
  assign rd_el  = mrd[32:0];

  // free slot search for add
  logic free_found;
  logic [AddrW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!act_q[i] && !pend_q[i]) begin
        free_found = 1'b1;
        free_idx = AddrW'(i);
      end
    end
  end

  // tick arithmetic on accept
  logic [63:0] dfull;
  logic [31:0] dclamp;
  logic [32:0] fsum_add, tps_eff;
  assign dfull = in_cv - prev_q;
  assign dclamp = (dfull > {32'd0, maxd_q}) ? maxd_q : dfull[31:0];
  assign fsum_add = sat_add33(fsum_q, {1'b0, dclamp});
  assign tps_eff = (tps_q == 32'd0) ? 33'd1 : {1'b0, tps_q};

  logic [AddrW-1:0] cur;
  assign cur = idx_q[AddrW-1:0];
  logic last_slot;
  assign last_slot = (idx_q == CntW'(TIMER_SLOTS - 1));

  // remove matching uses slot memory, so remove walks too
  logic is_rem_q;
  logic [15:0] tid_q;

  // elapsed update for the slot just read; read data holds until the next read
  logic [32:0] el_new;
  logic fire;
  assign el_new = sat_add33(rd_el, {1'b0, delta_q});
  assign fire = el_new >= {1'b0, rd_ivl};

  always_comb begin
    mwe = 1'b0; mwa = cur; mwd = '0;
    mre = 1'b0; mra = cur;
    push = 1'b0; res = '0;
    if (state_q == StIdle && acc && in_act == ActAdd && free_found) begin
      mwe = 1'b1; mwa = free_idx;
      mwd = {next_id_q, in_ivl, 33'd0};
    end
    if (state_q == StRead) mre = 1'b1;
    // el_q holds the updated elapsed count from the update cycle
    if (state_q == StEmit && !is_rem_q && act_q[cur]) begin
      mwe = 1'b1;
      mwd = {rd_id, rd_ivl, el_q};
    end
    if (state_q == StIdle && acc) begin
      case (in_act)
        ActStart: begin push = 1'b1; res.kind = KindAck; res.last = 1'b1; end
        ActAdd: begin
          push = 1'b1; res.kind = KindAdd; res.last = 1'b1;
          res.table_full = !free_found;
          res.timer_id = free_found ? 16'(next_id_q) : 16'd0;
        end
        default: ;
      endcase
    end
    if (state_q == StEmit && act_q[cur] && fire && !ofull) begin
      push = 1'b1; res.kind = KindFired; res.timer_id = 16'(rd_id);
    end
    if (state_q == StFinish && !ofull) begin
      push = 1'b1; res.last = 1'b1;
      res.kind = is_rem_q ? KindAck : KindTick;
      res.frame_rate = is_rem_q ? 32'd0 : rate_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tps_q <= TpsReset; maxd_q <= MaxDeltaReset;
      prev_q <= '0; frames_q <= '0; rate_q <= '0; fsum_q <= '0;
      next_id_q <= '0;
      act_q <= '0; pend_q <= '0; rem_q <= '0; loop_q <= '0;
      idx_q <= '0; is_rem_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegTps) tps_q <= cfg_wdata_i;
        else maxd_q <= cfg_wdata_i;
      end
      case (state_q)
        StIdle: if (acc) begin
          case (in_act)
            ActStart: prev_q <= in_cv;
            ActTick: begin
              prev_q <= in_cv;
              delta_q <= dclamp;
              if (fsum_add >= tps_eff) begin
                rate_q <= frames_q + 32'd1;
                frames_q <= '0;
                fsum_q <= fsum_add - tps_eff;
              end else begin
                frames_q <= frames_q + 32'd1;
                fsum_q <= fsum_add;
              end
              is_rem_q <= 1'b0; idx_q <= '0; state_q <= StRead;
            end
            ActAdd: if (free_found) begin
              pend_q[free_idx] <= 1'b1;
              loop_q[free_idx] <= in_rep;
              next_id_q <= next_id_q + 1'b1;
            end
            default: begin
              tid_q <= in_tid; is_rem_q <= 1'b1; idx_q <= '0; state_q <= StRead;
            end
          endcase
        end
        StRead: state_q <= StUpd;
        StUpd: begin
          if (is_rem_q) begin
            if (act_q[cur] && 16'(rd_id) == tid_q) rem_q[cur] <= 1'b1;
            state_q <= last_slot ? StFinish : StRead;
            idx_q <= idx_q + 1'b1;
          end else begin
            el_q <= (act_q[cur] && fire && loop_q[cur]) ? el_new - {1'b0, rd_ivl}
                                                         : el_new;
            state_q <= StEmit;
          end
        end
        StEmit: begin
          // write-back of the slot happens here, repeated harmlessly while stalled
          if (!act_q[cur] || !fire || !ofull) begin
            state_q <= last_slot ? StFinish : StRead;
            idx_q <= idx_q + 1'b1;
          end
        end
        StFinish: if (!ofull) begin
          if (!is_rem_q) begin
            for (int i = 0; i < TIMER_SLOTS; i++) begin
              if (rem_q[i]) begin
                act_q[i] <= 1'b0; pend_q[i] <= 1'b0; rem_q[i] <= 1'b0; loop_q[i] <= 1'b0;
              end else if (pend_q[i]) begin
                act_q[i] <= 1'b1; pend_q[i] <= 1'b0;
              end
            end
          end
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  ftb_out_stage u_out (
    .clk_i, .rst_ni, .push_i(push), .data_i(res), .full_o(ofull),
    .m_axis_tvalid, .m_axis_tready, .data_o(odata)
  );

  assign m_axis_tdata = {7'd0, odata.table_full, odata.frame_rate, odata.timer_id};
  assign m_axis_tuser = odata.kind;
  assign m_axis_tlast = odata.last;

  `FTB_ASSERT(a_busy_no_ready, clk_i, rst_ni, (state_q != StIdle) |-> !s_axis_tready)
  `FTB_ASSERT(a_no_push_full, clk_i, rst_ni, push |-> !ofull)
  `FTB_ASSERT(a_rem_only_active, clk_i, rst_ni, (rem_q & ~act_q) == '0)
endmodule
